// ===== hw/rtl/text_console_with_scrollback_core_assert.svh =====
// Assertion macros for the text console core.
// Needs a clock named clk and an active-low reset named rst_n in the including scope.
`ifndef TEXT_CONSOLE_WITH_SCROLLBACK_CORE_ASSERT_SVH
`define TEXT_CONSOLE_WITH_SCROLLBACK_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/tcs_pkg.sv =====
// Shared types and constants of the text console core.
// No dependencies; used by tcs_emit and text_console_with_scrollback_core.
package tcs_pkg;

  localparam logic [2:0] K_CHAR  = 3'd0;
  localparam logic [2:0] K_UP    = 3'd1;
  localparam logic [2:0] K_DOWN  = 3'd2;
  localparam logic [2:0] K_CLEAR = 3'd3;
  localparam logic [2:0] K_SETC  = 3'd4;
  localparam logic [2:0] K_READ  = 3'd5;

  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;

  localparam logic [15:0] RESET_CELL = 16'h0720;
  localparam logic [7:0]  RESET_ATTR = 8'h07;

  typedef enum logic [2:0] {
    EM_NONE, EM_CHAR, EM_NL, EM_CR, EM_BS, EM_TAB
  } emode_t;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_DECODE, ST_TAB, ST_SCR_COPY, ST_SCR_BLANK,
    ST_CLEAR, ST_READ, ST_DONE
  } state_t;

  typedef struct packed {
    emode_t      mode;
    logic [7:0]  ch;
    logic [3:0]  n;
    logic [15:0] cval;
    logic [4:0]  cy;
    logic [6:0]  cx;
    logic [8:0]  view;
  } job_t;

endpackage

// ===== hw/rtl/tcs_emit.sv =====
// Result emitter: holds one finished job and streams its result items.
// Depends on tcs_pkg (job_t, emode_t, character constants).
module tcs_emit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  tcs_pkg::job_t job,
  output logic          busy,
  output logic          out_tvalid,
  input  logic          out_tready,
  // serial_byte[7:0], cell_value[23:8], cursor_row[28:24], cursor_col[35:29],
  // cursor_visible[36], view_offset[45:37], zero[47:46]
  output logic [47:0]   out_tdata,
  // serial_valid[0]
  output logic          out_tuser,
  output logic          out_tlast
);

  tcs_pkg::job_t job_r;
  logic [3:0]    idx_r;
  logic          vld_r;
  logic [7:0]    byte_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else if (load) begin
      vld_r <= 1'b1;
      idx_r <= '0;
    end else if (vld_r && out_tready) begin
      if (out_tlast) vld_r <= 1'b0;
      idx_r <= idx_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) job_r <= job;
  end

  always_comb begin
    byte_w = 8'd0;
    case (job_r.mode)
      tcs_pkg::EM_CHAR: byte_w = job_r.ch;
      tcs_pkg::EM_NL:   byte_w = (idx_r == 4'd0) ? tcs_pkg::CH_CR : tcs_pkg::CH_NL;
      tcs_pkg::EM_CR:   byte_w = tcs_pkg::CH_CR;
      tcs_pkg::EM_BS:   byte_w = (idx_r == 4'd1) ? tcs_pkg::CH_SPACE : tcs_pkg::CH_BS;
      tcs_pkg::EM_TAB:  byte_w = tcs_pkg::CH_SPACE;
      default:          byte_w = 8'd0;
    endcase
  end

  assign busy       = vld_r;
  assign out_tvalid = vld_r;
  assign out_tuser  = (job_r.mode != tcs_pkg::EM_NONE);
  assign out_tlast  = (idx_r == job_r.n - 4'd1);
  assign out_tdata  = {2'b00, job_r.view, (job_r.view == 9'd0), job_r.cx, job_r.cy,
                       job_r.cval, byte_w};

endmodule

// ===== hw/rtl/text_console_with_scrollback_core.sv =====
// Text console core: cell screen, scrollback ring and serial echo of characters.
// A read passes through an extra read state; a scroll copies the top row to history,
//   then blanks it, and a clear sweeps every screen cell, one cell write a cycle on the
//   screen port.
// A new item is taken only back in idle, once the result went to the emitter; a tab
//   writes one space per cycle and ends at the next tab stop or at a line wrap.
// Reset: a clearing pass fills every screen cell with 0x0720.
module text_console_with_scrollback_core #(
  parameter int SCREEN_ROWS   = 24,
  parameter int SCREEN_COLS   = 80,
  parameter int HISTORY_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // char_code[7:0], line_count[15:8], row[20:16], col[27:21], zero[31:28]
  input  logic [31:0] in_tdata,
  // kind[2:0]
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // serial_byte[7:0], cell_value[23:8], cursor_row[28:24], cursor_col[35:29],
  // cursor_visible[36], view_offset[45:37], zero[47:46]
  output logic [47:0] out_tdata,
  // serial_valid[0]
  output logic        out_tuser,
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

`include "text_console_with_scrollback_core_assert.svh"

  localparam int SCELLS = SCREEN_ROWS * SCREEN_COLS;
  localparam int SAW    = $clog2(SCELLS);
  localparam int HW     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int HAW    = $clog2(HISTORY_DEPTH * SCREEN_COLS);
  localparam int VW     = $clog2(HISTORY_DEPTH + 1);
  localparam int UW     = ((VW > 8) ? VW : 8) + 1;
  localparam int HSW    = VW + 2;

  // Screen rows live in a ring: logical row r sits at physical row (top_r + r) mod SCREEN_ROWS.
  function automatic logic [SAW-1:0] scr_addr(input logic [4:0] top, input logic [4:0] row,
                                               input logic [6:0] col);
    logic [5:0] p;
    begin
      p = {1'b0, top} + {1'b0, row};
      if (p >= 6'(SCREEN_ROWS)) p = p - 6'(SCREEN_ROWS);
      scr_addr = SAW'(p) * SAW'(SCREEN_COLS) + SAW'(col);
    end
  endfunction

  function automatic logic [HAW-1:0] hist_addr(input logic [HW-1:0] line, input logic [6:0] col);
    hist_addr = HAW'(line) * HAW'(SCREEN_COLS) + HAW'(col);
  endfunction

  // Memories
  logic [15:0] scr_mem [SCELLS];
  logic [15:0] hist_mem [HISTORY_DEPTH * SCREEN_COLS];
  logic [15:0] scr_rdata_r, hist_rdata_r;
  logic           s_we, s_re, h_re;
  logic [SAW-1:0] s_addr;
  logic [15:0]    s_wdata;
  logic [HAW-1:0] h_raddr, h_waddr;

  always_ff @(posedge clk) begin
    if (s_we) scr_mem[s_addr] <= s_wdata;
    if (s_re) scr_rdata_r <= scr_mem[s_addr];
  end

  // State
  tcs_pkg::state_t st_r, st_nxt;
  logic [2:0]     kind_r, kind_nxt;
  logic [7:0]     ch_r, ch_nxt, cnt_r, cnt_nxt;
  logic [4:0]     row_r, row_nxt, cy_r, cy_nxt, top_r, top_nxt;
  logic [6:0]     col_r, col_nxt, cx_r, cx_nxt, pcol_r, pcol_nxt;
  logic [VW-1:0]  view_r, view_nxt, fill_r, fill_nxt;
  logic [HW-1:0]  wline_r, wline_nxt;
  logic [7:0]     attr_r, ccol_r, ccol_nxt, stop_r, stop_nxt;
  logic [SAW-1:0] sweep_r, sweep_nxt;
  logic [3:0]     ecnt_r, ecnt_nxt;
  tcs_pkg::emode_t emode_r, emode_nxt;
  logic [15:0]    cell_r, cell_nxt;
  logic           rd_hist_r, rd_hist_nxt, pend_r, pend_nxt;

  always_ff @(posedge clk) begin
    if (pend_r) hist_mem[h_waddr] <= scr_rdata_r;
    if (h_re) hist_rdata_r <= hist_mem[h_raddr];
  end

  logic           emit_busy, emit_load;
  tcs_pkg::job_t  job;

  // Cursor advance shared by plain characters, tabs and newline
  logic [7:0]  cx1;
  logic [5:0]  cy1;
  logic        wrap, scroll_nl;
  logic [15:0] blank;
  logic [UW-1:0]  up_sum;
  logic [HSW-1:0] hsum;
  logic [VW-1:0]  vmod;
  logic [4:0]     lrow, bs_y;
  logic [6:0]     bs_x;

  assign cx1       = {1'b0, cx_r} + 8'd1;
  assign cy1       = {1'b0, cy_r} + 6'd1;
  assign wrap      = (cx1 >= 8'(SCREEN_COLS));
  assign scroll_nl = (cy1 >= 6'(SCREEN_ROWS));
  assign blank     = {attr_r, tcs_pkg::CH_SPACE};
  assign up_sum    = UW'(view_r) + UW'(cnt_r);
  assign vmod      = (view_r == VW'(HISTORY_DEPTH)) ? '0 : view_r;
  assign lrow      = row_r - 5'(view_r);
  assign h_waddr   = hist_addr(wline_r, pcol_r);

  assign cfg_ready = 1'b1;
  assign in_tready = (st_r == tcs_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) attr_r <= tcs_pkg::RESET_ATTR;
    else if (cfg_valid) attr_r <= cfg_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= tcs_pkg::ST_INIT;
      cy_r    <= '0;
      cx_r    <= '0;
      top_r   <= '0;
      view_r  <= '0;
      fill_r  <= '0;
      wline_r <= '0;
      sweep_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      cy_r    <= cy_nxt;
      cx_r    <= cx_nxt;
      top_r   <= top_nxt;
      view_r  <= view_nxt;
      fill_r  <= fill_nxt;
      wline_r <= wline_nxt;
      sweep_r <= sweep_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    ch_r      <= ch_nxt;
    cnt_r     <= cnt_nxt;
    row_r     <= row_nxt;
    col_r     <= col_nxt;
    pcol_r    <= pcol_nxt;
    ccol_r    <= ccol_nxt;
    stop_r    <= stop_nxt;
    ecnt_r    <= ecnt_nxt;
    emode_r   <= emode_nxt;
    cell_r    <= cell_nxt;
    rd_hist_r <= rd_hist_nxt;
  end

  always_comb begin
    st_nxt = st_r;  kind_nxt = kind_r;  ch_nxt = ch_r;  cnt_nxt = cnt_r;
    row_nxt = row_r;  col_nxt = col_r;  cy_nxt = cy_r;  cx_nxt = cx_r;
    top_nxt = top_r;  view_nxt = view_r;  fill_nxt = fill_r;  wline_nxt = wline_r;
    ccol_nxt = ccol_r;  stop_nxt = stop_r;  sweep_nxt = sweep_r;  ecnt_nxt = ecnt_r;
    emode_nxt = emode_r;  cell_nxt = cell_r;  rd_hist_nxt = rd_hist_r;
    pcol_nxt = pcol_r;  pend_nxt = 1'b0;
    s_we = 1'b0;  s_re = 1'b0;  h_re = 1'b0;
    s_addr = scr_addr(top_r, cy_r, cx_r);
    s_wdata = blank;
    h_raddr = '0;
    emit_load = 1'b0;
    bs_x = cx_r;  bs_y = cy_r;
    hsum = '0;

    case (st_r)
      tcs_pkg::ST_INIT, tcs_pkg::ST_CLEAR: begin
        // sweep every physical cell, one write a cycle
        s_we    = 1'b1;
        s_addr  = sweep_r;
        s_wdata = (st_r == tcs_pkg::ST_INIT) ? tcs_pkg::RESET_CELL : blank;
        sweep_nxt = sweep_r + SAW'(1);
        if (sweep_r == SAW'(SCELLS - 1)) begin
          sweep_nxt = '0;
          if (st_r == tcs_pkg::ST_INIT) begin
            st_nxt = tcs_pkg::ST_IDLE;
          end else begin
            cy_nxt = '0;
            cx_nxt = '0;
            st_nxt = tcs_pkg::ST_DONE;
          end
        end
      end

      tcs_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          kind_nxt = in_tuser;
          ch_nxt   = in_tdata[7:0];
          cnt_nxt  = in_tdata[15:8];
          row_nxt  = in_tdata[20:16];
          col_nxt  = in_tdata[27:21];
          st_nxt   = tcs_pkg::ST_DECODE;
        end
      end

      tcs_pkg::ST_DECODE: begin
        emode_nxt = tcs_pkg::EM_NONE;
        cell_nxt  = '0;
        ccol_nxt  = '0;
        st_nxt    = tcs_pkg::ST_DONE;
        case (kind_r)
          tcs_pkg::K_CHAR: begin
            view_nxt = '0;
            case (ch_r)
              tcs_pkg::CH_NL: begin
                emode_nxt = tcs_pkg::EM_NL;
                cx_nxt = '0;
                if (scroll_nl) st_nxt = tcs_pkg::ST_SCR_COPY;
                else cy_nxt = cy1[4:0];
              end
              tcs_pkg::CH_CR: begin
                emode_nxt = tcs_pkg::EM_CR;
                cx_nxt = '0;
              end
              tcs_pkg::CH_BS: begin
                emode_nxt = tcs_pkg::EM_BS;
                if (cx_r != 7'd0) begin
                  bs_x = cx_r - 7'd1;
                end else if (cy_r != 5'd0) begin
                  bs_y = cy_r - 5'd1;
                  bs_x = 7'(SCREEN_COLS - 1);
                end
                cx_nxt = bs_x;
                cy_nxt = bs_y;
                s_we   = 1'b1;
                s_addr = scr_addr(top_r, bs_y, bs_x);
              end
              tcs_pkg::CH_TAB: begin
                emode_nxt = tcs_pkg::EM_TAB;
                ecnt_nxt  = '0;
                stop_nxt  = ({1'b0, cx_r} + 8'd8) & 8'hF8;
                st_nxt    = tcs_pkg::ST_TAB;
              end
              default: begin
                emode_nxt = tcs_pkg::EM_CHAR;
                s_we    = 1'b1;
                s_wdata = {attr_r, ch_r};
                if (wrap) begin
                  cx_nxt = '0;
                  if (scroll_nl) st_nxt = tcs_pkg::ST_SCR_COPY;
                  else cy_nxt = cy1[4:0];
                end else begin
                  cx_nxt = cx1[6:0];
                end
              end
            endcase
          end
          tcs_pkg::K_UP: begin
            view_nxt = (up_sum > UW'(fill_r)) ? fill_r : VW'(up_sum);
          end
          tcs_pkg::K_DOWN: begin
            view_nxt = (UW'(view_r) > UW'(cnt_r)) ? VW'(UW'(view_r) - UW'(cnt_r)) : '0;
          end
          tcs_pkg::K_CLEAR: begin
            view_nxt  = '0;
            sweep_nxt = '0;
            st_nxt    = tcs_pkg::ST_CLEAR;
          end
          tcs_pkg::K_SETC: begin
            if (row_r < 5'(SCREEN_ROWS - 1) || row_r == 5'(SCREEN_ROWS - 1)) cy_nxt = row_r;
            if ({1'b0, col_r} < 8'(SCREEN_COLS)) cx_nxt = col_r;
          end
          tcs_pkg::K_READ: begin
            if ({1'b0, row_r} < 6'(SCREEN_ROWS) && {1'b0, col_r} < 8'(SCREEN_COLS)) begin
              st_nxt = tcs_pkg::ST_READ;
              if (UW'(row_r) < UW'(view_r)) begin
                // history line (write_line - view + row) mod depth
                rd_hist_nxt = 1'b1;
                hsum = HSW'(wline_r) + HSW'(HISTORY_DEPTH) - HSW'(vmod) + HSW'(row_r);
                if (hsum >= HSW'(2 * HISTORY_DEPTH)) hsum = hsum - HSW'(2 * HISTORY_DEPTH);
                else if (hsum >= HSW'(HISTORY_DEPTH)) hsum = hsum - HSW'(HISTORY_DEPTH);
                h_re    = 1'b1;
                h_raddr = hist_addr(HW'(hsum), col_r);
              end else begin
                rd_hist_nxt = 1'b0;
                s_re   = 1'b1;
                s_addr = scr_addr(top_r, lrow, col_r);
              end
            end
          end
          default: begin
          end
        endcase
      end

      tcs_pkg::ST_TAB: begin
        if ({1'b0, cx_r} < stop_r) begin
          s_we     = 1'b1;
          ecnt_nxt = ecnt_r + 4'd1;
          if (wrap) begin
            cx_nxt = '0;
            st_nxt = tcs_pkg::ST_DONE;
            ccol_nxt = '0;
            if (scroll_nl) st_nxt = tcs_pkg::ST_SCR_COPY;
            else cy_nxt = cy1[4:0];
          end else begin
            cx_nxt = cx1[6:0];
          end
        end else begin
          st_nxt = tcs_pkg::ST_DONE;
        end
      end

      tcs_pkg::ST_SCR_COPY: begin
        // read the top row; the history write follows in the next cycle
        s_re     = 1'b1;
        s_addr   = scr_addr(top_r, 5'd0, ccol_r[6:0]);
        pend_nxt = 1'b1;
        pcol_nxt = ccol_r[6:0];
        ccol_nxt = ccol_r + 8'd1;
        if (ccol_r == 8'(SCREEN_COLS - 1)) begin
          ccol_nxt = '0;
          st_nxt   = tcs_pkg::ST_SCR_BLANK;
        end
      end

      tcs_pkg::ST_SCR_BLANK: begin
        // old top row becomes the new bottom row
        s_we     = 1'b1;
        s_addr   = scr_addr(top_r, 5'd0, ccol_r[6:0]);
        ccol_nxt = ccol_r + 8'd1;
        if (ccol_r == 8'(SCREEN_COLS - 1)) begin
          ccol_nxt  = '0;
          top_nxt   = (top_r == 5'(SCREEN_ROWS - 1)) ? '0 : top_r + 5'd1;
          wline_nxt = (wline_r == HW'(HISTORY_DEPTH - 1)) ? '0 : wline_r + HW'(1);
          if (fill_r < VW'(HISTORY_DEPTH)) fill_nxt = fill_r + VW'(1);
          cy_nxt = 5'(SCREEN_ROWS - 1);
          st_nxt = tcs_pkg::ST_DONE;
        end
      end

      tcs_pkg::ST_READ: begin
        cell_nxt = rd_hist_r ? hist_rdata_r : scr_rdata_r;
        st_nxt   = tcs_pkg::ST_DONE;
      end

      tcs_pkg::ST_DONE: begin
        // hand the result over once the emitter is free
        if (!emit_busy) begin
          emit_load = 1'b1;
          st_nxt    = tcs_pkg::ST_IDLE;
        end
      end

      default: st_nxt = tcs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    job.mode = emode_r;
    job.ch   = ch_r;
    job.cval = cell_r;
    job.cy   = cy_r;
    job.cx   = cx_r;
    job.view = 9'(view_r);
    case (emode_r)
      tcs_pkg::EM_NL:  job.n = 4'd2;
      tcs_pkg::EM_BS:  job.n = 4'd3;
      tcs_pkg::EM_TAB: job.n = ecnt_r;
      default:         job.n = 4'd1;
    endcase
  end

  tcs_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (emit_load),
    .job        (job),
    .busy       (emit_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  `TCS_ASSERT_SAME(a_view_clamped, 1'b1, view_r <= fill_r, "view offset above history fill")
  `TCS_ASSERT_SAME(a_cursor_range, st_r == tcs_pkg::ST_IDLE,
    {1'b0, cx_r} < 8'(SCREEN_COLS) && {1'b0, cy_r} < 6'(SCREEN_ROWS), "cursor off screen")
  `TCS_ASSERT_NEXT(a_accept_busy, in_tvalid && in_tready, st_r == tcs_pkg::ST_DECODE,
    "accepted item not decoded")

endmodule
